### design/pnu_pkg.sv
package pnu_pkg;

  localparam int ValueWidth         = 32;
  localparam int DistWidth          = 16;
  localparam int CountWidth         = 8;
  localparam int DefaultMaxChildren = 254;

  localparam logic [ValueWidth-1:0] InfinityReset = '1;
  localparam logic [DistWidth-1:0]  DistSentinel  = '1;

  // One summarized node, as handed from the accumulator to the result register.
  typedef struct packed {
    logic [ValueWidth-1:0] node_pn;
    logic [ValueWidth-1:0] node_dn;
    logic                  node_repeated;
    logic [DistWidth-1:0]  node_distance;
    logic                  best_found;
    logic [CountWidth-1:0] best_index;
    logic [ValueWidth-1:0] next_pn_limit;
    logic [ValueWidth-1:0] next_dn_limit;
  } node_result_t;

  // One child request as held in the input register.
  typedef struct packed {
    logic                  attacker_node;
    logic [ValueWidth-1:0] parent_pn_limit;
    logic [ValueWidth-1:0] parent_dn_limit;
    logic [ValueWidth-1:0] child_pn;
    logic [ValueWidth-1:0] child_dn;
    logic                  child_repeated;
    logic [DistWidth-1:0]  child_distance;
    logic                  last_child;
  } child_req_t;

endpackage

### design/proof_number_node_update.sv
// Proof-number node summarizer. Children of one search node arrive one request
// per cycle; the first child fixes whether the node is an attacker (OR) or a
// defender (AND) node, and the child flagged last_child_i closes the node and
// produces one result: proof and disproof numbers (minimum on one side,
// saturating sum on the other), the OR of repeated flags, the proven mate
// distance plus one, the first child with the least selection number, and
// the thresholds to hand to that child. Children past the first MAX_CHILDREN
// of a node are ignored, but a last mark on one still closes the node. The
// block takes one child per cycle unless a closing child waits for the result
// register: a request is captured in an input register, folded into the
// running node values by combinational logic in the accumulator, and a closing
// child's summary is loaded into the result register as that child leaves the
// input register. Input and output are decoupled by the result register, so
// new children keep flowing while a result waits; only a closing child waits
// for that register to free up.
// The infinity register sets the saturation ceiling and must be written
// while the block is idle.
module proof_number_node_update #(
  parameter int MAX_CHILDREN = pnu_pkg::DefaultMaxChildren
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [pnu_pkg::ValueWidth-1:0] cfg_wdata_i,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           attacker_node_i,
  input  logic [pnu_pkg::ValueWidth-1:0] parent_pn_limit_i,
  input  logic [pnu_pkg::ValueWidth-1:0] parent_dn_limit_i,
  input  logic [pnu_pkg::ValueWidth-1:0] child_pn_i,
  input  logic [pnu_pkg::ValueWidth-1:0] child_dn_i,
  input  logic                           child_repeated_i,
  input  logic [pnu_pkg::DistWidth-1:0]  child_distance_i,
  input  logic                           last_child_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pnu_pkg::ValueWidth-1:0] node_pn_o,
  output logic [pnu_pkg::ValueWidth-1:0] node_dn_o,
  output logic                           node_repeated_o,
  output logic [pnu_pkg::DistWidth-1:0]  node_distance_o,
  output logic                           best_found_o,
  output logic [pnu_pkg::CountWidth-1:0] best_index_o,
  output logic [pnu_pkg::ValueWidth-1:0] next_pn_limit_o,
  output logic [pnu_pkg::ValueWidth-1:0] next_dn_limit_o
);

  // Saturation ceiling, written by the configuration port.
  logic [pnu_pkg::ValueWidth-1:0] infinity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infinity_q <= pnu_pkg::InfinityReset;
    end else if (cfg_we_i) begin
      infinity_q <= cfg_wdata_i;
    end
  end

  // Input register holding one child request.
  logic                s1_valid_q, s1_valid_d;
  pnu_pkg::child_req_t s1_req_q;
  logic                s1_step;
  logic                res_free;
  logic                in_fire;

  // A child that does not close its node never needs the result register,
  // so it moves on at once; a closing child waits until that register is free.
  assign s1_step    = s1_valid_q && (!s1_req_q.last_child || res_free);
  assign in_ready_o = !s1_valid_q || s1_step;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q.attacker_node   <= attacker_node_i;
      s1_req_q.parent_pn_limit <= parent_pn_limit_i;
      s1_req_q.parent_dn_limit <= parent_dn_limit_i;
      s1_req_q.child_pn        <= child_pn_i;
      s1_req_q.child_dn        <= child_dn_i;
      s1_req_q.child_repeated  <= child_repeated_i;
      s1_req_q.child_distance  <= child_distance_i;
      s1_req_q.last_child      <= last_child_i;
    end
  end

  // Running node values and the summary of the node closed this cycle.
  pnu_pkg::node_result_t node_result;
  pnu_pkg::node_result_t out_result;

  pnu_accum #(
    .MaxChildren (MAX_CHILDREN)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_step),
    .req_i      (s1_req_q),
    .infinity_i (infinity_q),
    .result_o   (node_result)
  );

  pnu_result_reg u_result_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_step && s1_req_q.last_child),
    .data_i  (node_result),
    .free_o  (res_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_result)
  );

  assign node_pn_o       = out_result.node_pn;
  assign node_dn_o       = out_result.node_dn;
  assign node_repeated_o = out_result.node_repeated;
  assign node_distance_o = out_result.node_distance;
  assign best_found_o    = out_result.best_found;
  assign best_index_o    = out_result.best_index;
  assign next_pn_limit_o = out_result.next_pn_limit;
  assign next_dn_limit_o = out_result.next_dn_limit;

endmodule

### design/pnu_accum.sv
module pnu_accum #(
  parameter int MaxChildren = pnu_pkg::DefaultMaxChildren
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  pnu_pkg::child_req_t               req_i,
  input  logic [pnu_pkg::ValueWidth-1:0]    infinity_i,
  output pnu_pkg::node_result_t             result_o
);

  localparam int VW = pnu_pkg::ValueWidth;
  localparam int DW = pnu_pkg::DistWidth;
  localparam int CW = pnu_pkg::CountWidth;
  localparam logic [CW-1:0] MaxCount = CW'(MaxChildren);

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a,
                                            input logic [VW-1:0] b,
                                            input logic [VW-1:0] ceil);
    logic [VW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum >= {1'b0, ceil}) ? ceil : sum[VW-1:0];
  endfunction

  logic          mode_q,   mode_d;
  logic [CW-1:0] count_q,  count_d;
  logic [VW-1:0] least_q,  least_d;
  logic [VW-1:0] second_q, second_d;
  logic [CW-1:0] index_q,  index_d;
  logic          found_q,  found_d;
  logic [VW-1:0] sum_q,    sum_d;
  logic          repeat_q, repeat_d;
  logic [DW-1:0] dist_q,   dist_d;

  logic          start;
  logic          take;
  logic [VW-1:0] sel_val;
  logic [VW-1:0] acc_val;
  logic [VW-1:0] limit;

  always_comb begin
    start = (count_q == '0);
    take  = (count_q < MaxCount);

    // A node's first child starts from fresh running values.
    mode_d   = start ? req_i.attacker_node : mode_q;
    least_d  = start ? infinity_i : least_q;
    second_d = start ? infinity_i : second_q;
    index_d  = start ? '0 : index_q;
    found_d  = start ? 1'b0 : found_q;
    sum_d    = start ? '0 : sum_q;
    repeat_d = start ? 1'b0 : repeat_q;
    if (start) begin
      dist_d = req_i.attacker_node ? pnu_pkg::DistSentinel : '0;
    end else begin
      dist_d = dist_q;
    end
    count_d = count_q;

    sel_val = mode_d ? req_i.child_pn : req_i.child_dn;
    acc_val = mode_d ? req_i.child_dn : req_i.child_pn;

    // Children beyond the node's capacity leave every running value alone.
    if (take) begin
      if (sel_val < least_d) begin
        second_d = least_d;
        least_d  = sel_val;
        index_d  = count_q;
        found_d  = 1'b1;
      end else if (sel_val < second_d) begin
        second_d = sel_val;
      end
      sum_d    = sat_add(sum_d, acc_val, infinity_i);
      repeat_d = repeat_d | req_i.child_repeated;
      if (req_i.child_pn == '0) begin
        if (mode_d) begin
          if (req_i.child_distance < dist_d) dist_d = req_i.child_distance;
        end else begin
          if (req_i.child_distance > dist_d) dist_d = req_i.child_distance;
        end
      end
      count_d = count_q + CW'(1);
    end

    if (req_i.last_child) begin
      count_d = '0;
    end
  end

  always_comb begin
    result_o.node_pn       = mode_d ? least_d : sum_d;
    result_o.node_dn       = mode_d ? sum_d : least_d;
    result_o.node_repeated = repeat_d;
    if (result_o.node_pn == '0 && dist_d != pnu_pkg::DistSentinel) begin
      result_o.node_distance = dist_d + DW'(1);
    end else begin
      result_o.node_distance = '0;
    end
    result_o.best_found    = found_d;
    result_o.best_index    = found_d ? index_d : '0;

    limit                  = sat_add(second_d, VW'(1), infinity_i);
    result_o.next_pn_limit = req_i.parent_pn_limit;
    result_o.next_dn_limit = req_i.parent_dn_limit;
    if (found_d) begin
      if (mode_d) begin
        if (limit < req_i.parent_pn_limit) result_o.next_pn_limit = limit;
      end else begin
        if (limit < req_i.parent_dn_limit) result_o.next_dn_limit = limit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      count_q  <= '0;
      least_q  <= pnu_pkg::InfinityReset;
      second_q <= pnu_pkg::InfinityReset;
      index_q  <= '0;
      found_q  <= 1'b0;
      sum_q    <= '0;
      repeat_q <= 1'b0;
      dist_q   <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      count_q  <= count_d;
      least_q  <= least_d;
      second_q <= second_d;
      index_q  <= index_d;
      found_q  <= found_d;
      sum_q    <= sum_d;
      repeat_q <= repeat_d;
      dist_q   <= dist_d;
    end
  end

endmodule

### design/pnu_result_reg.sv
module pnu_result_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  pnu_pkg::node_result_t data_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output pnu_pkg::node_result_t data_o
);

  logic                  valid_q, valid_d;
  pnu_pkg::node_result_t data_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
